/* src/stcs_pkg.sv */
package stcs_pkg;

    localparam int unsigned NUM_DIGITS  = 4;
    localparam int unsigned DIGIT_IDX_W = 2;

    localparam logic [DIGIT_IDX_W-1:0] FIRST_DIGIT = 2'd0;
    localparam logic [DIGIT_IDX_W-1:0] LAST_DIGIT  = 2'd3;

    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [6:0]  HOUR_CAP      = 7'd99;
    localparam logic [3:0]  TEN           = 4'd10;
    localparam logic [7:0]  COLON_BIT     = 8'h80;
    localparam logic [7:0]  BLANK_CODE    = 8'h00;

    // Reciprocals for exact division by constants over the input ranges used.
    // hours   = ((t >> 4) * HOUR_RECIP) >> 36, t >> 4 below 2**28
    // minutes = (rem * MIN_RECIP) >> 18,       rem below 2**12
    // tens    = (v * TEN_RECIP) >> 11,         v below 2**7
    localparam logic [28:0] HOUR_RECIP = 29'd305419897;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;
    localparam logic [7:0]  TEN_RECIP  = 8'd205;

    localparam logic [7:0] SEG_TABLE [16] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam logic [6:0] ADDR_TABLE [NUM_DIGITS] = '{7'h68, 7'h6A, 7'h6C, 7'h6E};

    typedef struct packed {
        logic [3:0] hi_tens;
        logic [3:0] hi_ones;
        logic [3:0] lo_tens;
        logic [3:0] lo_ones;
    } digit_set_t;

    typedef struct packed {
        logic       valid;
        digit_set_t digits;
    } digit_item_t;

endpackage

/* src/seconds_to_clock_segments.sv */
// Seconds-to-clock-segments: push an elapsed time in whole seconds and pop four
// display-register writes, one per digit, at addresses 0x68, 0x6A, 0x6C, 0x6E;
// last_write marks the fourth. Under one hour the digits read MM:SS, otherwise
// HH:MM with hours capped at 99. A zero first digit is blanked and the second digit
// carries bit 7 for the colon. Sustained throughput is set by the result port,
// which moves one write per cycle while pop is held. A new item is taken every
// cycle until the digit queue and the six-stage front pipeline fill up; an item
// passes the front stages, the queue and the back's holding register on its way
// to the result ports. Reset clears all control state at once, with no clearing pass.
module seconds_to_clock_segments #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] elapsed_secs,
    output logic        empty,
    input  logic        pop,
    output logic [6:0]  digit_address,
    output logic [7:0]  segment_code,
    output logic        last_write
);
    import stcs_pkg::*;

    digit_item_t front_item;
    digit_item_t queue_item;
    logic        queue_full;
    logic        queue_pop;

    // Front: split the count into hours, minutes, seconds and the four digits.
    stcs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .elapsed_secs (elapsed_secs),
        .full         (full),
        .item         (front_item),
        .queue_full   (queue_full)
    );

    // Queue: hold digit sets so the front keeps accepting while writes drain.
    stcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (front_item),
        .in_full  (queue_full),
        .out_item (queue_item),
        .out_pop  (queue_pop)
    );

    // Back: walk the four digits, map them to segments and present each write.
    stcs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (queue_item),
        .q_pop         (queue_pop),
        .empty         (empty),
        .pop           (pop),
        .digit_address (digit_address),
        .segment_code  (segment_code),
        .last_write    (last_write)
    );

endmodule

/* src/stcs_front.sv */
module stcs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [31:0]          elapsed_secs,
    output logic                 full,
    output stcs_pkg::digit_item_t item,
    input  logic                 queue_full
);
    import stcs_pkg::*;

    logic advance;

    logic [5:0] valid_reg, valid_next;

    // stage 1: raw count
    logic [31:0] t1_reg;
    // stage 2: hours
    logic [20:0] hours2_reg;
    logic [11:0] tlow2_reg;
    // stage 3: remainder within the hour
    logic [11:0] rem3_reg;
    logic        hzero3_reg;
    logic [6:0]  hcap3_reg;
    // stage 4: minutes
    logic [5:0]  min4_reg;
    logic [5:0]  remlow4_reg;
    logic        hzero4_reg;
    logic [6:0]  hcap4_reg;
    // stage 5: the two displayed pairs
    logic [6:0]  hi5_reg;
    logic [6:0]  lo5_reg;
    // stage 6: tens digits
    logic [3:0]  hi_tens6_reg;
    logic [3:0]  lo_tens6_reg;
    logic [3:0]  hi_low6_reg;
    logic [3:0]  lo_low6_reg;

    logic [56:0] hour_prod;
    logic [32:0] hour_back;
    logic [24:0] min_prod;
    logic [11:0] min_back;
    logic [5:0]  seconds;
    logic [14:0] hi_prod;
    logic [14:0] lo_prod;
    logic [7:0]  hi_back;
    logic [7:0]  lo_back;

    // Stall the whole line only when the last stage holds an item the queue cannot take.
    assign advance = !valid_reg[5] || !queue_full;
    assign full    = !advance;

    assign valid_next = {valid_reg[4:0], push};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    assign hour_prod = 57'(t1_reg[31:4]) * 57'(HOUR_RECIP);
    assign hour_back = 33'(hours2_reg) * 33'(SECS_PER_HOUR);
    assign min_prod  = 25'(rem3_reg) * 25'(MIN_RECIP);
    assign min_back  = 12'(min4_reg) * 12'(SECS_PER_MIN);
    assign seconds   = remlow4_reg - min_back[5:0];
    assign hi_prod   = 15'(hi5_reg) * 15'(TEN_RECIP);
    assign lo_prod   = 15'(lo5_reg) * 15'(TEN_RECIP);
    assign hi_back   = 8'(hi_tens6_reg) * 8'(TEN);
    assign lo_back   = 8'(lo_tens6_reg) * 8'(TEN);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t1_reg       <= elapsed_secs;

            hours2_reg   <= hour_prod[56:36];
            tlow2_reg    <= t1_reg[11:0];

            rem3_reg     <= tlow2_reg - hour_back[11:0];
            hzero3_reg   <= (hours2_reg == '0);
            hcap3_reg    <= (hours2_reg > 21'(HOUR_CAP)) ? HOUR_CAP : hours2_reg[6:0];

            min4_reg     <= min_prod[23:18];
            remlow4_reg  <= rem3_reg[5:0];
            hzero4_reg   <= hzero3_reg;
            hcap4_reg    <= hcap3_reg;

            hi5_reg      <= hzero4_reg ? 7'(min4_reg) : hcap4_reg;
            lo5_reg      <= hzero4_reg ? 7'(seconds) : 7'(min4_reg);

            hi_tens6_reg <= hi_prod[14:11];
            lo_tens6_reg <= lo_prod[14:11];
            hi_low6_reg  <= hi5_reg[3:0];
            lo_low6_reg  <= lo5_reg[3:0];
        end
    end

    assign item.valid          = valid_reg[5];
    assign item.digits.hi_tens = hi_tens6_reg;
    assign item.digits.hi_ones = hi_low6_reg - hi_back[3:0];
    assign item.digits.lo_tens = lo_tens6_reg;
    assign item.digits.lo_ones = lo_low6_reg - lo_back[3:0];

endmodule

/* src/stcs_queue.sv */
module stcs_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stcs_pkg::digit_item_t in_item,
    output logic                  in_full,
    output stcs_pkg::digit_item_t out_item,
    input  logic                  out_pop
);
    import stcs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    digit_set_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign in_full  = (count_reg == CNT_W'(DEPTH));
    assign do_push  = in_item.valid && !in_full;
    assign do_pop   = out_pop && (count_reg != '0);

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= in_item.digits;
        end
    end

    assign out_item.valid  = (count_reg != '0);
    assign out_item.digits = mem[rd_ptr_reg];

endmodule

/* src/stcs_back.sv */
module stcs_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stcs_pkg::digit_item_t q_item,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [6:0]            digit_address,
    output logic [7:0]            segment_code,
    output logic                  last_write
);
    import stcs_pkg::*;

    logic                   valid_reg;
    logic [DIGIT_IDX_W-1:0] index_reg;
    digit_set_t             digits_reg;
    logic                   is_last;
    logic                   taken;
    logic [3:0]             cur_digit;

    assign is_last = (index_reg == LAST_DIGIT);
    assign taken   = valid_reg && pop;
    // Refill when idle or when the final write of the held item leaves.
    assign q_pop   = q_item.valid && (!valid_reg || (taken && is_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            index_reg <= FIRST_DIGIT;
        end
        else if (q_pop)
        begin
            valid_reg <= 1'b1;
            index_reg <= FIRST_DIGIT;
        end
        else if (taken)
        begin
            if (is_last)
            begin
                valid_reg <= 1'b0;
            end
            index_reg <= index_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            digits_reg <= q_item.digits;
        end
    end

    always_comb
    begin
        unique case (index_reg)
            2'd0:    cur_digit = digits_reg.hi_tens;
            2'd1:    cur_digit = digits_reg.hi_ones;
            2'd2:    cur_digit = digits_reg.lo_tens;
            default: cur_digit = digits_reg.lo_ones;
        endcase
    end

    always_comb
    begin
        priority if (index_reg == FIRST_DIGIT && cur_digit == '0)
        begin
            segment_code = BLANK_CODE;
        end
        else if (index_reg == FIRST_DIGIT + 1'b1)
        begin
            segment_code = SEG_TABLE[cur_digit] | COLON_BIT;
        end
        else
        begin
            segment_code = SEG_TABLE[cur_digit];
        end
    end

    assign empty         = !valid_reg;
    assign digit_address = ADDR_TABLE[index_reg];
    assign last_write    = is_last;

endmodule

/* src/stcs_checker.sv */
module stcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [6:0]  digit_address,
    input logic [7:0]  segment_code,
    input logic        last_write
);
    import stcs_pkg::*;

    // The final write of an item always targets the fourth digit.
    a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_write) |-> (digit_address == ADDR_TABLE[3]))
        else $error("last write not at fourth digit address");

    // The writes of one item come back to back, in address order.
    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_write) |=>
            (!empty && digit_address == $past(digit_address) + 7'd2))
        else $error("write sequence broken inside an item");

    // The second digit always lights the colon.
    a_colon: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && digit_address == ADDR_TABLE[1]) |-> segment_code[7])
        else $error("colon bit missing on second digit");

    // A waiting write holds until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(digit_address) && $stable(segment_code)))
        else $error("result changed while stalled");

endmodule

bind seconds_to_clock_segments stcs_checker u_checker (.*);
